FILE: design/tlo_pkg.sv
// ----------------------------------------------------------------------------
// tlo_pkg: shared types and constants for the tiled layout offset block
// Register index codes and reset values of the configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

package tlo_pkg;

    localparam int CFG_IDX_BITS = 2;

    // Configuration register index codes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_TILE_ROWS    = 2'd0,
        CFG_TILE_COLS    = 2'd1,
        CFG_MATRIX_WIDTH = 2'd2
    } t_cfg_idx;

    localparam int RESET_TILE_DIM     = 4096;
    localparam int RESET_MATRIX_WIDTH = 4096;

endpackage

`default_nettype wire

FILE: design/tlo_req_if.sv
// ----------------------------------------------------------------------------
// tlo_req_if: coordinate request channel
// valid/ready handshake carrying one element coordinate per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlo_req_if #(
    parameter int COORD_BITS = 24
) ();
    logic                  valid;
    logic                  ready;
    logic                  operation;
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] col;

    modport source (output valid, output operation, output row, output col, input ready);
    modport sink   (input valid, input operation, input row, input col, output ready);
endinterface

`default_nettype wire

FILE: design/tlo_rsp_if.sv
// ----------------------------------------------------------------------------
// tlo_rsp_if: offset result channel
// valid/ready handshake carrying one byte offset per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlo_rsp_if #(
    parameter int OFFSET_BITS = 48
) ();
    logic                   valid;
    logic                   ready;
    logic [OFFSET_BITS-1:0] offset;

    modport source (output valid, output offset, input ready);
    modport sink   (input valid, input offset, output ready);
endinterface

`default_nettype wire

FILE: design/tlo_div.sv
// ----------------------------------------------------------------------------
// tlo_div: pipelined restoring divider
// One quotient bit per stage, NUM_BITS stages, advances when i_en is high.
// ----------------------------------------------------------------------------
`default_nettype none

module tlo_div #(
    parameter int NUM_BITS = 25,
    parameter int DEN_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [NUM_BITS-1:0] i_num,
    input  logic [DEN_BITS-1:0] i_den,
    output logic [NUM_BITS-1:0] o_quot,
    output logic [DEN_BITS-1:0] o_rem
);

    // Per stage: partial remainder and the dividend bits still to shift in,
    // with quotient bits filling from the bottom.
    logic [DEN_BITS-1:0] r_rem [NUM_BITS];
    logic [NUM_BITS-1:0] r_quo [NUM_BITS];

    for (genvar k = 0; k < NUM_BITS; k++) begin : g_stage
        logic [DEN_BITS-1:0] rem_in;
        logic [NUM_BITS-1:0] quo_in;
        logic [DEN_BITS:0]   trial;
        logic                fits;
        logic [DEN_BITS-1:0] n_rem;
        logic [NUM_BITS-1:0] n_quo;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign quo_in = i_num;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign quo_in = r_quo[k-1];
        end

        assign trial = {rem_in, quo_in[NUM_BITS-1]};
        assign fits  = trial >= {1'b0, i_den};
        assign n_rem = fits ? DEN_BITS'(trial - {1'b0, i_den}) : trial[DEN_BITS-1:0];
        assign n_quo = {quo_in[NUM_BITS-2:0], fits};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_quo[k] <= n_quo;
            end
        end
    end

    assign o_quot = r_quo[NUM_BITS-1];
    assign o_rem  = r_rem[NUM_BITS-1];

endmodule

`default_nettype wire

FILE: design/tiled_layout_offset.sv
// ----------------------------------------------------------------------------
// tiled_layout_offset: byte offset of a matrix element in a tile-blocked store
// Takes coordinate transactions and returns their offsets in order. The
// pipeline rests on the pipelined dividers: one pipeline stage per dividend bit
// (COORD_BITS + 1 stages), preceded by an input register and followed by
// five stages of multiply and add and the output register. Throughput is one
// transaction per cycle unless a finished result is held by a stalled output.
// With operation 0 the coordinates are input-matrix (row, col); with
// operation 1 they are transposed output coordinates and each tile is
// stored transposed with stride tile_rows. Tiles per tile row is
// ceil(matrix_width / tile_cols). A zero tile dimension or any result beyond
// the offset width returns all ones. Configuration registers may only be
// written while no transaction is in flight or waiting at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module tiled_layout_offset #(
    parameter int COORD_BITS  = 24,
    parameter int TILE_BITS   = 16,
    parameter int OFFSET_BITS = 48,
    localparam int CfgBits    = (TILE_BITS > COORD_BITS) ? TILE_BITS : COORD_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tlo_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [CfgBits-1:0]              i_cfg_data,
    tlo_req_if.sink                         i_req,
    tlo_rsp_if.source                       o_rsp
);

    localparam int C       = COORD_BITS;
    localparam int T       = TILE_BITS;
    localparam int O       = OFFSET_BITS;
    localparam int DivN    = C + 1;          // holds matrix_width + tile_cols - 1
    localparam int ProdW   = 2 * C;          // tile row index * tiles per row
    localparam int TileW   = 2 * C + 1;      // plus tile column index
    localparam int WideW   = (TileW > O) ? TileW : O;
    localparam int AreaW   = 2 * T;          // tile_rows * tile_cols
    localparam int LoW     = (O + 1) / 2;    // split of tile number for the area product
    localparam int HiW     = O - LoW;
    localparam int PlW     = LoW + AreaW;
    localparam int PhW     = HiW + AreaW;
    localparam int BaseW   = O + AreaW;
    localparam int SumW    = BaseW + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [T-1:0] r_tile_rows;
    logic [T-1:0] r_tile_cols;
    logic [C-1:0] r_matrix_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_rows    <= T'(tlo_pkg::RESET_TILE_DIM);
            r_tile_cols    <= T'(tlo_pkg::RESET_TILE_DIM);
            r_matrix_width <= C'(tlo_pkg::RESET_MATRIX_WIDTH);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tlo_pkg::CFG_TILE_ROWS:    r_tile_rows    <= i_cfg_data[T-1:0];
                tlo_pkg::CFG_TILE_COLS:    r_tile_cols    <= i_cfg_data[T-1:0];
                tlo_pkg::CFG_MATRIX_WIDTH: r_matrix_width <= i_cfg_data[C-1:0];
                default: ;  // unused index: ignored
            endcase
        end
    end

    // Derived from configuration only; settles long before an item needs it
    logic [AreaW-1:0] r_area;
    logic             r_tile_zero;

    always_ff @(posedge i_clk) begin
        r_area      <= AreaW'(r_tile_rows) * AreaW'(r_tile_cols);
        r_tile_zero <= (r_tile_rows == '0) || (r_tile_cols == '0);
    end

    // ------------------------------------------------------------------
    // Flow control: the whole pipe advances unless the last stage holds a
    // result that cannot move into a stalled output register. Bubbles do
    // not drain then, and no input is taken while a result waits.
    // ------------------------------------------------------------------
    logic r_s0_v;
    logic r_dv [DivN];
    logic r_m1_v, r_m2_v, r_m3_v, r_m4_v, r_m5_v;
    logic r_o_valid;
    logic w_adv;

    assign w_adv       = !r_m5_v || !r_o_valid || o_rsp.ready;
    assign i_req.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v    <= 1'b0;
            r_dv      <= '{default: 1'b0};
            r_m1_v    <= 1'b0;
            r_m2_v    <= 1'b0;
            r_m3_v    <= 1'b0;
            r_m4_v    <= 1'b0;
            r_m5_v    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_s0_v <= i_req.valid;
                r_dv[0] <= r_s0_v;
                for (int k = 1; k < DivN; k++) begin
                    r_dv[k] <= r_dv[k-1];
                end
                r_m1_v <= r_dv[DivN-1];
                r_m2_v <= r_m1_v;
                r_m3_v <= r_m2_v;
                r_m4_v <= r_m3_v;
                r_m5_v <= r_m4_v;
            end
            if (!r_o_valid || o_rsp.ready) begin
                r_o_valid <= r_m5_v;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: pick dividends. Dividend A goes over tile_rows, B over
    // tile_cols; the third divider gives tiles per tile row.
    // ------------------------------------------------------------------
    logic         r_s0_op;
    logic [C-1:0] r_s0_num_a;
    logic [C-1:0] r_s0_num_b;
    logic [C:0]   r_s0_num_t;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s0_op    <= i_req.operation;
            r_s0_num_a <= i_req.operation ? i_req.col : i_req.row;
            r_s0_num_b <= i_req.operation ? i_req.row : i_req.col;
            r_s0_num_t <= {1'b0, r_matrix_width} + (C+1)'(r_tile_cols) - (C+1)'(1);
        end
    end

    // Operation bit rides alongside the divider stages
    logic r_dop [DivN];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dop[0] <= r_s0_op;
            for (int k = 1; k < DivN; k++) begin
                r_dop[k] <= r_dop[k-1];
            end
        end
    end

    logic [DivN-1:0] w_quot_a, w_quot_b, w_quot_t;
    logic [T-1:0]    w_rem_a, w_rem_b;

    tlo_div #(.NUM_BITS(DivN), .DEN_BITS(T)) u_div_a (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_num  ({1'b0, r_s0_num_a}),
        .i_den  (r_tile_rows),
        .o_quot (w_quot_a),
        .o_rem  (w_rem_a)
    );

    tlo_div #(.NUM_BITS(DivN), .DEN_BITS(T)) u_div_b (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_num  ({1'b0, r_s0_num_b}),
        .i_den  (r_tile_cols),
        .o_quot (w_quot_b),
        .o_rem  (w_rem_b)
    );

    // Remainder of the tiles-per-row division is not needed
    tlo_div #(.NUM_BITS(DivN), .DEN_BITS(T)) u_div_t (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_num  (r_s0_num_t),
        .i_den  (r_tile_cols),
        .o_quot (w_quot_t),
        .o_rem  ()
    );

    // ------------------------------------------------------------------
    // M1: tile row * tiles per row, and the in-tile product.
    // Input order:  inner = rem_a * tile_cols + rem_b
    // Transposed:   inner = rem_b * tile_rows + rem_a
    // Quotients are below 2^C, so the top bit is dropped.
    // ------------------------------------------------------------------
    logic [ProdW-1:0] r_m1_prod;
    logic [C-1:0]     r_m1_tcol;
    logic [AreaW-1:0] r_m1_iprod;
    logic [T-1:0]     r_m1_iadd;
    logic [T-1:0]     n_mul_a;
    logic [T-1:0]     n_mul_b;
    logic             w_op;

    assign w_op    = r_dop[DivN-1];
    assign n_mul_a = w_op ? w_rem_b : w_rem_a;
    assign n_mul_b = w_op ? r_tile_rows : r_tile_cols;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m1_prod  <= ProdW'(w_quot_a[C-1:0]) * ProdW'(w_quot_t[C-1:0]);
            r_m1_tcol  <= w_quot_b[C-1:0];
            r_m1_iprod <= AreaW'(n_mul_a) * AreaW'(n_mul_b);
            r_m1_iadd  <= w_op ? w_rem_a : w_rem_b;
        end
    end

    // ------------------------------------------------------------------
    // M2: tile number and in-tile offset (inner < tile area, no carry out)
    // ------------------------------------------------------------------
    logic [TileW-1:0] r_m2_tile;
    logic [AreaW-1:0] r_m2_inner;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m2_tile  <= TileW'(r_m1_prod) + TileW'(r_m1_tcol);
            r_m2_inner <= r_m1_iprod + AreaW'(r_m1_iadd);
        end
    end

    // ------------------------------------------------------------------
    // M3: tile number above the offset range saturates on its own (area is
    // at least one); otherwise multiply by the area in two halves.
    // ------------------------------------------------------------------
    logic [WideW-1:0] n_tile_ext;
    logic [O-1:0]     n_tile_t;
    logic [PlW-1:0]   r_m3_pp_lo;
    logic [PhW-1:0]   r_m3_pp_hi;
    logic             r_m3_ovf;
    logic [AreaW-1:0] r_m3_inner;

    assign n_tile_ext = WideW'(r_m2_tile);
    assign n_tile_t   = n_tile_ext[O-1:0];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m3_pp_lo <= PlW'(n_tile_t[LoW-1:0]) * PlW'(r_area);
            r_m3_pp_hi <= PhW'(n_tile_t[O-1:LoW]) * PhW'(r_area);
            r_m3_ovf   <= (n_tile_ext >> O) != '0;
            r_m3_inner <= r_m2_inner;
        end
    end

    // ------------------------------------------------------------------
    // M4: combine the partial products into the tile base
    // ------------------------------------------------------------------
    logic [BaseW-1:0] r_m4_base;
    logic             r_m4_ovf;
    logic [AreaW-1:0] r_m4_inner;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m4_base  <= BaseW'(r_m3_pp_lo) + (BaseW'(r_m3_pp_hi) << LoW);
            r_m4_ovf   <= r_m3_ovf;
            r_m4_inner <= r_m3_inner;
        end
    end

    // ------------------------------------------------------------------
    // M5: add in-tile offset and saturate
    // ------------------------------------------------------------------
    logic [SumW-1:0] n_sum;
    logic            n_sat;
    logic [O-1:0]    r_m5_offset;

    assign n_sum = SumW'(r_m4_base) + SumW'(r_m4_inner);
    assign n_sat = r_m4_ovf || r_tile_zero || ((n_sum >> O) != '0);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m5_offset <= n_sat ? '1 : n_sum[O-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [O-1:0] r_o_offset;

    always_ff @(posedge i_clk) begin
        if (!r_o_valid || o_rsp.ready) begin
            r_o_offset <= r_m5_offset;
        end
    end

    assign o_rsp.valid  = r_o_valid;
    assign o_rsp.offset = r_o_offset;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A finished result blocked by the output must stay put
    a_hold_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m5_v && r_o_valid && !o_rsp.ready |=> r_m5_v && $stable(r_m5_offset))
        else $error("last stage changed while output stalled");

    // A result that can move must appear at the output unchanged
    a_move_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m5_v && (!r_o_valid || o_rsp.ready)
            |=> r_o_valid && (o_rsp.offset == $past(r_m5_offset)))
        else $error("result lost between last stage and output");

    // No transaction appears without a result behind it
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_m5_v && (!r_o_valid || o_rsp.ready) |=> !r_o_valid)
        else $error("output valid without a pending result");

endmodule

`default_nettype wire

FILE: verif/tlo_offset_checker.sv
// ----------------------------------------------------------------------------
// tlo_offset_checker: offset predictor and scoreboard for tiled_layout_offset
// Shadows the layout registers from the write port, predicts the byte offset
// of every accepted coordinate transaction and compares each accepted result,
// in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module tlo_offset_checker #(
    parameter int COORD_BITS  = 24,
    parameter int TILE_BITS   = 16,
    parameter int OFFSET_BITS = 48,
    parameter int CFG_BITS    = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tlo_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [CFG_BITS-1:0]             i_cfg_data,
    tlo_req_if                              i_req,
    tlo_rsp_if                              i_rsp,
    output int                              o_errors,
    output int                              o_pending
);

    logic [TILE_BITS-1:0]   tile_rows;
    logic [TILE_BITS-1:0]   tile_cols;
    logic [COORD_BITS-1:0]  matrix_width;
    logic [OFFSET_BITS-1:0] expected_offsets[$];
    int                     mismatches = 0;

    // Exact arithmetic in 128 bits; the largest product stays below 2^81,
    // so clamping once at the end equals saturating each step.
    function automatic logic [OFFSET_BITS-1:0] tiled_offset(
        input logic                  op,
        input logic [COORD_BITS-1:0] row,
        input logic [COORD_BITS-1:0] col
    );
        logic [127:0]           tr;
        logic [127:0]           tc;
        logic [127:0]           tiles_per_row;
        logic [127:0]           tile_row;
        logic [127:0]           tile_col;
        logic [127:0]           inner;
        logic [127:0]           exact;
        logic [OFFSET_BITS-1:0] ceiling;
        ceiling = '1;
        tr      = 128'(tile_rows);
        tc      = 128'(tile_cols);
        if (tr == 0 || tc == 0)
            return ceiling;
        tiles_per_row = (128'(matrix_width) + tc - 1) / tc;
        if (!op) begin
            tile_row = 128'(row) / tr;
            tile_col = 128'(col) / tc;
            inner    = (128'(row) % tr) * tc + 128'(col) % tc;
        end else begin
            // transposed tile: stride is tile_rows
            tile_row = 128'(col) / tr;
            tile_col = 128'(row) / tc;
            inner    = (128'(row) % tc) * tr + 128'(col) % tr;
        end
        exact = (tile_row * tiles_per_row + tile_col) * tr * tc + inner;
        return (exact > 128'(ceiling)) ? ceiling : exact[OFFSET_BITS-1:0];
    endfunction

    always @(posedge i_clk) begin
        logic [OFFSET_BITS-1:0] want;
        if (!i_rst_n) begin
            tile_rows    <= TILE_BITS'(tlo_pkg::RESET_TILE_DIM);
            tile_cols    <= TILE_BITS'(tlo_pkg::RESET_TILE_DIM);
            matrix_width <= COORD_BITS'(tlo_pkg::RESET_MATRIX_WIDTH);
            expected_offsets.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_offsets.size() == 0) begin
                    mismatches++;
                    $display("%0t: offset %h arrived, none expected",
                             $time, i_rsp.offset);
                end else begin
                    want = expected_offsets.pop_front();
                    if (i_rsp.offset !== want) begin
                        mismatches++;
                        $display("%0t: offset mismatch, expected %h, got %h",
                                 $time, want, i_rsp.offset);
                    end
                end
            end
            // the item sees the registers as they were before this edge
            if (i_req.valid && i_req.ready)
                expected_offsets.push_back(tiled_offset(i_req.operation,
                                                        i_req.row, i_req.col));
            if (i_cfg_we) begin
                case (tlo_pkg::t_cfg_idx'(i_cfg_idx))
                    tlo_pkg::CFG_TILE_ROWS:    tile_rows    <= i_cfg_data[TILE_BITS-1:0];
                    tlo_pkg::CFG_TILE_COLS:    tile_cols    <= i_cfg_data[TILE_BITS-1:0];
                    tlo_pkg::CFG_MATRIX_WIDTH: matrix_width <= i_cfg_data[COORD_BITS-1:0];
                    default: ;
                endcase
            end
        end
        o_errors  <= mismatches;
        o_pending <= expected_offsets.size();
    end

endmodule

FILE: verif/tiled_layout_offset_tb.sv
// ----------------------------------------------------------------------------
// tiled_layout_offset_tb: testbench top for the tiled layout offset block
// Drives coordinate transactions under a series of tile layouts, from a
// directed set of corner cases to randomized layouts and coordinates, with
// random idle bursts on the request and result channels. Checking is done
// by tlo_offset_checker, which sits beside the block.
// ----------------------------------------------------------------------------
module tiled_layout_offset_tb;

    localparam int COORD_BITS  = 24;
    localparam int TILE_BITS   = 16;
    localparam int OFFSET_BITS = 48;
    localparam int CFG_BITS    = (TILE_BITS > COORD_BITS) ? TILE_BITS : COORD_BITS;
    localparam int IDX_BITS    = tlo_pkg::CFG_IDX_BITS;

    // pipeline depth: input register, divider stages, multiply-add stages and output register
    localparam int LATENCY       = COORD_BITS + 8;
    // cycles without any transaction, write or reset before giving up
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_LAYOUTS = 10;
    localparam int LAYOUT_ITEMS  = 83;
    // layouts at the tail run with both channels streaming
    localparam int QUIET_LAYOUTS = 2;

    // index 3 decodes to no register; writes to it must be dropped
    localparam logic [IDX_BITS-1:0] CFG_IDX_SPARE = 2'd3;

    localparam logic [COORD_BITS-1:0] COORD_MAX  = '1;
    localparam logic [TILE_BITS-1:0]  TILE_MAX   = '1;

    logic                    clk      = 1'b0;
    logic                    rst_n    = 1'b0;
    logic                    cfg_we   = 1'b0;
    logic [IDX_BITS-1:0]     cfg_idx  = '0;
    logic [CFG_BITS-1:0]     cfg_data = '0;

    // idle bursts allowed on either channel while set
    logic bursty = 1'b1;

    int errors;
    int pending;
    int coords_sent  = 0;
    int offsets_seen = 0;
    int layouts_used = 0;

    // current layout, used only to aim coordinates at tile boundaries
    int cur_rows = tlo_pkg::RESET_TILE_DIM;
    int cur_cols = tlo_pkg::RESET_TILE_DIM;

    tlo_req_if #(.COORD_BITS(COORD_BITS))   req_ch ();
    tlo_rsp_if #(.OFFSET_BITS(OFFSET_BITS)) rsp_ch ();

    tiled_layout_offset #(
        .COORD_BITS (COORD_BITS),
        .TILE_BITS  (TILE_BITS),
        .OFFSET_BITS(OFFSET_BITS)
    ) dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_req     (req_ch),
        .o_rsp     (rsp_ch)
    );

    tlo_offset_checker #(
        .COORD_BITS (COORD_BITS),
        .TILE_BITS  (TILE_BITS),
        .OFFSET_BITS(OFFSET_BITS),
        .CFG_BITS   (CFG_BITS)
    ) checker_i (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_req     (req_ch),
        .i_rsp     (rsp_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always #5 clk = ~clk;

    initial begin
        req_ch.valid     = 1'b0;
        req_ch.operation = 1'b0;
        req_ch.row       = '0;
        req_ch.col       = '0;
    end

    // Transaction counts for the summary.
    always @(posedge clk) begin
        if (req_ch.valid && req_ch.ready)
            coords_sent <= coords_sent + 1;
        if (rsp_ch.valid && rsp_ch.ready)
            offsets_seen <= offsets_seen + 1;
    end

    // Result side: ready drops low at random while bursty,
    // otherwise stays high. One assignment per edge at most.
    initial begin : result_sink
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (bursty && $urandom_range(0, 3) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9) - 1) @(posedge clk);
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: any activity restarts the count.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || cfg_we || (req_ch.valid && req_ch.ready) ||
                (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no progress for %0d cycles, %0d offsets outstanding",
                 $time, STALL_LIMIT, pending);
        $display("tiled_layout_offset_tb NOT OK");
        $finish;
    end

    // Called just after the clock rises. Optionally idles the request channel,
    // then presents one coordinate and holds it until accepted.
    task automatic send_coord(input logic op, input logic [COORD_BITS-1:0] row,
                              input logic [COORD_BITS-1:0] col);
        if (bursty && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.row       <= row;
        req_ch.col       <= col;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    // Stop sending and wait until every predicted offset has come back,
    // then let the pipeline run empty before touching the registers.
    task automatic drain_offsets();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // Back-to-back writes keep the enable high; the caller lowers it.
    task automatic write_reg(input logic [IDX_BITS-1:0] idx,
                             input logic [CFG_BITS-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    // New layout. Tile dimensions go out with random upper bits, which the
    // block must drop.
    task automatic set_layout(input int rows, input int cols, input int width);
        drain_offsets();
        write_reg(tlo_pkg::CFG_TILE_ROWS, {8'($urandom), TILE_BITS'(rows)});
        write_reg(tlo_pkg::CFG_TILE_COLS, {8'($urandom), TILE_BITS'(cols)});
        write_reg(tlo_pkg::CFG_MATRIX_WIDTH, CFG_BITS'(width));
        cfg_we   <= 1'b0;
        cur_rows = rows;
        cur_cols = cols;
        layouts_used++;
    endtask

    // Coordinates: full random, extremes, near tile boundaries, or small.
    function automatic logic [COORD_BITS-1:0] pick_coord(input int dim);
        longint pick;
        int     step;
        step = (dim == 0) ? 1 : dim;
        case ($urandom_range(0, 9))
            0, 1, 2: pick = longint'(COORD_BITS'($urandom));
            3:       pick = $urandom_range(0, 1) ? longint'(COORD_MAX) : 0;
            4, 5, 6: pick = longint'($urandom_range(0, 64)) * step
                            + $urandom_range(0, 2) - 1;
            default: pick = $urandom_range(0, 4 * step + 8);
        endcase
        if (pick < 0)
            pick = 0;
        if (pick > longint'(COORD_MAX))
            pick = longint'(COORD_MAX);
        return COORD_BITS'(pick);
    endfunction

    // Random layouts, weighted toward small tiles where many boundaries are
    // crossed, with zero dimensions and extremes mixed in.
    task automatic random_layout();
        int rows;
        int cols;
        int width;
        case ($urandom_range(0, 9))
            0: begin
                rows  = $urandom_range(0, 1) ? 0 : $urandom_range(1, 100);
                cols  = (rows == 0) ? $urandom_range(0, 100) : 0;
                width = $urandom_range(0, 1000);
            end
            1: begin
                rows  = $urandom_range(0, 1) ? 1 : int'(TILE_MAX);
                cols  = $urandom_range(0, 1) ? 1 : int'(TILE_MAX);
                case ($urandom_range(0, 2))
                    0:       width = 0;
                    1:       width = 1;
                    default: width = int'(COORD_MAX);
                endcase
            end
            2, 3, 4, 5: begin
                rows  = $urandom_range(1, 16);
                cols  = $urandom_range(1, 16);
                width = $urandom_range(1, 200);
            end
            6, 7: begin
                rows  = $urandom_range(1, 4096);
                cols  = $urandom_range(1, 4096);
                width = $urandom_range(1, int'(COORD_MAX));
            end
            default: begin
                rows  = int'(TILE_BITS'($urandom));
                cols  = int'(TILE_BITS'($urandom));
                width = int'(COORD_BITS'($urandom));
            end
        endcase
        set_layout(rows, cols, width);
    endtask

    initial begin : stimulus
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Reset layout: 4096 x 4096 tiles, width 4096.
        send_coord(1'b0, '0, '0);
        send_coord(1'b1, '0, '0);
        send_coord(1'b0, COORD_MAX, COORD_MAX);
        send_coord(1'b1, COORD_MAX, COORD_MAX);
        send_coord(1'b0, 24'd4095, 24'd4097);
        send_coord(1'b1, 24'd4097, 24'd4095);

        // Unit tiles on the widest matrix: offset runs close to the top.
        set_layout(1, 1, int'(COORD_MAX));
        send_coord(1'b0, COORD_MAX, COORD_MAX);
        send_coord(1'b1, COORD_MAX, COORD_MAX);

        // Largest tiles: the far corner saturates.
        set_layout(int'(TILE_MAX), int'(TILE_MAX), int'(COORD_MAX));
        send_coord(1'b0, COORD_MAX, COORD_MAX);
        send_coord(1'b1, COORD_MAX, COORD_MAX);

        // Thin tiles on a wide matrix: a large tile count brings the offset close to the top.
        set_layout(2, 1, int'(COORD_MAX));
        send_coord(1'b0, COORD_MAX, COORD_MAX);
        send_coord(1'b1, COORD_MAX, COORD_MAX);

        // Empty tiles in either dimension give the all-ones offset.
        set_layout(0, 7, 100);
        send_coord(1'b0, 24'd5, 24'd5);
        send_coord(1'b1, 24'd5, 24'd5);
        set_layout(5, 0, 100);
        send_coord(1'b0, 24'd1, 24'd2);

        // Zero width, written with upper bits set on the tile dimensions,
        // then a write to the unmapped index which must change nothing.
        drain_offsets();
        write_reg(tlo_pkg::CFG_TILE_ROWS, 24'hA50003);
        write_reg(tlo_pkg::CFG_TILE_COLS, 24'h5A0005);
        write_reg(tlo_pkg::CFG_MATRIX_WIDTH, '0);
        write_reg(CFG_IDX_SPARE, 24'h000001);
        cfg_we   <= 1'b0;
        cur_rows = 3;
        cur_cols = 5;
        layouts_used++;
        send_coord(1'b0, 24'd7, 24'd12);
        send_coord(1'b1, 24'd12, 24'd7);
        send_coord(1'b0, COORD_MAX, COORD_MAX);

        // Random layouts and coordinates; the last few stream without gaps.
        for (int l = 0; l < RANDOM_LAYOUTS; l++) begin
            random_layout();
            if (l >= RANDOM_LAYOUTS - QUIET_LAYOUTS)
                bursty = 1'b0;
            for (int n = 0; n < LAYOUT_ITEMS; n++)
                send_coord(1'($urandom), pick_coord(cur_rows), pick_coord(cur_cols));
        end

        // Flush, then leave room for any stray result to show up.
        drain_offsets();
        repeat (LATENCY + 8) @(posedge clk);

        $display("Ran %0d coordinate transactions, %0d offsets back, over %0d tile layouts.",
                 coords_sent, offsets_seen, layouts_used);
        $display("Both orderings, empty tiles, zero width, masked writes and saturation hit.");
        if (errors == 0 && pending == 0)
            $display("tiled_layout_offset_tb OK");
        else
            $display("tiled_layout_offset_tb NOT OK");
        $finish;
    end

endmodule

FILE: filelist.f
design/tlo_pkg.sv
design/tlo_req_if.sv
design/tlo_rsp_if.sv
design/tlo_div.sv
design/tiled_layout_offset.sv
verif/tlo_offset_checker.sv
verif/tiled_layout_offset_tb.sv
